// ----- src/urlpd_pkg.sv -----
// Shared types, codes and character-class functions of the URL percent decoder.
// No dependencies; imported by every module of the block.
package urlpd_pkg;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // escape phase codes
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_HI    = 2'd2;

  // register index (paddr bit 2) of output_capacity
  localparam logic REG_CAPACITY = 1'b0;

  localparam int          AW           = 3;
  localparam logic [15:0] CAP_RESET    = 16'hFFFF;
  localparam logic [7:0]  CH_PERCENT   = 8'h25;
  localparam logic [7:0]  CH_PLUS      = 8'h2B;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_TILDE     = 8'h7E;
  localparam logic [7:0]  CH_DASH      = 8'h2D;
  localparam logic [7:0]  CH_UNDER     = 8'h5F;
  localparam logic [7:0]  CH_DOT       = 8'h2E;

  // one result beat
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic [1:0]  status;
    logic [15:0] byte_count;
  } result_t;

  // hex digit value; bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b inside {[8'h30:8'h39]}) v = {1'b0, b[3:0]};
    else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) v = {1'b0, b[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) ||
           b == CH_DASH || b == CH_UNDER || b == CH_DOT || b == CH_TILDE;
  endfunction

endpackage

// ----- src/urlpd_regs.sv -----
// Configuration register file of the URL percent decoder (APB-style port).
// Depends on urlpd_pkg.
module urlpd_regs
  import urlpd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output logic [15:0]   capacity_o
);

  logic [15:0] cap_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (wr_en) begin
      cap_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_CAPACITY) prdata = {16'd0, cap_q};
  end

  assign capacity_o = cap_q;

endmodule

// ----- src/urlpd_core.sv -----
// Per-byte decode step: message state registers and the combinational update.
// Depends on urlpd_pkg.
module urlpd_core
  import urlpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  in_byte_i,
  input  logic        last_i,
  input  logic [15:0] capacity_i,
  output result_t     result_o
);

  logic [1:0]  phase_q, phase_d;
  logic [4:0]  first_q, first_d;
  logic        stop_q, stop_d;
  logic [1:0]  cause_q, cause_d;
  logic [15:0] count_q, count_d;

  logic [4:0]  hex;
  logic [15:0] count_inc;
  logic        emit;
  logic [7:0]  emit_byte;
  logic [7:0]  wr_val;
  logic        do_write;

  assign hex       = hex_value(in_byte_i);
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    first_d   = first_q;
    stop_d    = stop_q;
    cause_d   = cause_q;
    count_d   = count_q;
    do_write  = 1'b0;
    wr_val    = 8'd0;

    if (!stop_q) begin
      if (phase_q == PH_HI) begin
        phase_d = PH_PLAIN;
        if (first_q[4] || hex[4]) begin
          stop_d  = 1'b1;
          cause_d = ST_INVALID;
        end else begin
          do_write = 1'b1;
          wr_val   = {first_q[3:0], hex[3:0]};
        end
      end else if (phase_q == PH_PCT && !last_i) begin
        first_d = hex;
        phase_d = PH_HI;
      end else begin
        phase_d = PH_PLAIN;
        if (count_q >= capacity_i) begin
          stop_d  = 1'b1;
          cause_d = ST_FULL;
        end else if (in_byte_i == CH_PERCENT) begin
          if (!last_i) phase_d = PH_PCT;
        end else if (in_byte_i == CH_PLUS) begin
          do_write = 1'b1;
          wr_val   = CH_SPACE;
        end else if (is_unreserved(in_byte_i)) begin
          do_write = 1'b1;
          wr_val   = in_byte_i;
        end else begin
          stop_d  = 1'b1;
          cause_d = ST_INVALID;
        end
      end
    end

    if (do_write) begin
      count_d = count_inc;
      if (count_inc >= capacity_i) begin
        stop_d  = 1'b1;
        cause_d = ST_FULL;
      end
    end
  end

  assign emit      = do_write;
  assign emit_byte = wr_val;

  always_comb begin
    result_o.data_valid     = emit;
    result_o.data_byte      = emit_byte;
    result_o.end_of_message = last_i;
    result_o.status         = stop_d ? cause_d : ST_OK;
    result_o.byte_count     = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      first_q <= 5'd0;
      stop_q  <= 1'b0;
      cause_q <= ST_OK;
      count_q <= 16'd0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_PLAIN;
        first_q <= 5'd0;
        stop_q  <= 1'b0;
        cause_q <= ST_OK;
        count_q <= 16'd0;
      end else begin
        phase_q <= phase_d;
        first_q <= first_d;
        stop_q  <= stop_d;
        cause_q <= cause_d;
        count_q <= count_d;
      end
    end
  end

endmodule

// ----- src/url_percent_decoder.sv -----
// Top level of the URL percent decoder: input stage, decode step, result stage.
// Depends on urlpd_pkg, urlpd_regs and urlpd_core.
// An accepted input beat is registered in the input stage, then in the result stage.
// Throughput: one byte per cycle unless m_axis_tready stalls; urlpd_core state updates per beat.
// Both stages advance whenever the result register is empty or being drained.
// Reset (async, active low) empties both stages, clears the message state, capacity = 65535.
module url_percent_decoder
  import urlpd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave side: tdata = in_byte[7:0]; tlast = last
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,
  input  logic          s_axis_tlast,
  // master side: tdata = data_byte[7:0], byte_count[23:8]
  //              tuser = data_valid[0], status[2:1]; tlast = end_of_message
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_vld_q;
  result_t     out_res_q;
  result_t     step_res;
  logic [15:0] capacity;
  logic        out_free;
  logic        advance;

  urlpd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .capacity_o(capacity)
  );

  // result register can take a beat when empty or draining this cycle
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || advance;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // decode step; message state updates only when the beat moves on
  urlpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .in_byte_i (in_byte_q),
    .last_i    (in_last_q),
    .capacity_i(capacity),
    .result_o  (step_res)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_res_q <= step_res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_res_q.byte_count, out_res_q.data_byte};
  assign m_axis_tuser  = {out_res_q.status, out_res_q.data_valid};
  assign m_axis_tlast  = out_res_q.end_of_message;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench of url_percent_decoder: a directed table, then random messages, with every
// result beat checked against an in-bench decode model. Depends on urlpd_pkg and the RTL.
module tb_top;
  import urlpd_pkg::*;

  localparam int RAND_BEATS  = 550;   // random beats to send after the table
  localparam int PHASE_MSGS  = 10;    // messages per capacity setting
  localparam int SETTLE_CYC  = 4;     // pipe is 2 deep, leave margin before a reg write
  localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side

  logic          clk_i;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata  = '0;  // in_byte[7:0]
  logic          s_axis_tlast  = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [23:0]   m_axis_tdata;        // data_byte[7:0], byte_count[23:8]
  logic [2:0]    m_axis_tuser;        // data_valid[0], status[2:1]
  logic          m_axis_tlast;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [AW-1:0] paddr         = '0;
  logic [31:0]   pwdata        = '0;
  logic [31:0]   prdata;
  logic          pready;

  url_percent_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decode model: own copy of the capacity reg and the per-message state.
  // Only the monitor steps it; the capacity copy is written while the DUT is idle.
  // ---------------------------------------------------------------------------
  logic [15:0] cap_q     = CAP_RESET;
  logic [1:0]  esc_q     = PH_PLAIN;
  logic [4:0]  hi_q      = '0;       // first hex digit, bit 4 = not a digit
  logic        halted_q  = 1'b0;
  logic [1:0]  cause_q   = ST_OK;
  logic [15:0] written_q = '0;

  result_t expected_decodes [$];
  int      mismatches  = 0;
  int      beats_sent  = 0;
  logic    calm        = 1'b0;       // no idling on either side while set

  // sideband that travels with each input beat: a typed-in expectation from the table
  logic    row_typed = 1'b0;
  result_t row_exp   = '0;

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return 5'h10;   // anything else, bytes of 128 and up included
  endfunction

  // one decoded byte out; the capacity is checked again right after the write
  function automatic void put_byte(inout result_t r, input logic [7:0] v);
    r.data_valid = 1'b1;
    r.data_byte  = v;
    written_q    = written_q + 16'd1;
    if (written_q >= cap_q) begin
      halted_q = 1'b1;
      cause_q  = ST_FULL;
    end
  endfunction

  function automatic result_t decode_byte(input logic [7:0] c, input logic fin);
    result_t r;
    logic [4:0] lo;
    r = '0;
    if (!halted_q) begin
      if (esc_q == PH_HI) begin
        // second digit: the pair is judged only now
        lo    = hex_nibble(c);
        esc_q = PH_PLAIN;
        if (hi_q[4] || lo[4]) begin
          halted_q = 1'b1;
          cause_q  = ST_INVALID;
        end else begin
          put_byte(r, {hi_q[3:0], lo[3:0]});
        end
      end else if (esc_q == PH_PCT && !fin) begin
        hi_q  = hex_nibble(c);
        esc_q = PH_HI;
      end else begin
        // new character; a '%' right before the last byte falls through to here
        esc_q = PH_PLAIN;
        if (written_q >= cap_q) begin
          halted_q = 1'b1;
          cause_q  = ST_FULL;
        end else if (c == CH_PERCENT) begin
          if (!fin) esc_q = PH_PCT;      // '%' as the final byte gives nothing
        end else if (c == CH_PLUS) begin
          put_byte(r, CH_SPACE);
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER ||
                     c == CH_DOT || c == CH_TILDE) begin
          put_byte(r, c);
        end else begin
          halted_q = 1'b1;
          cause_q  = ST_INVALID;
        end
      end
    end
    r.end_of_message = fin;
    r.status         = halted_q ? cause_q : ST_OK;
    r.byte_count     = written_q;
    if (fin) begin
      esc_q     = PH_PLAIN;
      hi_q      = '0;
      halted_q  = 1'b0;
      cause_q   = ST_OK;
      written_q = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. A row is either a capacity write or one input beat; beats
  // with an obvious result carry it typed in, the rest go to the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        is_cfg;
    logic [15:0] cap;
    logic [7:0]  c;
    logic        fin;
    logic        typed;
    result_t     exp;
  } row_t;

  function automatic row_t plain_row(input logic [7:0] c, input logic fin);
    return '{is_cfg: 1'b0, cap: '0, c: c, fin: fin, typed: 1'b0, exp: '0};
  endfunction

  function automatic row_t known_row(input logic [7:0] c, input logic fin, input logic dv,
                                     input logic [7:0] db, input logic [1:0] st,
                                     input logic [15:0] n);
    return '{is_cfg: 1'b0, cap: '0, c: c, fin: fin, typed: 1'b1,
             exp: '{data_valid: dv, data_byte: db, end_of_message: fin,
                    status: st, byte_count: n}};
  endfunction

  function automatic row_t cap_row(input logic [15:0] v);
    return '{is_cfg: 1'b1, cap: v, c: '0, fin: 1'b0, typed: 1'b0, exp: '0};
  endfunction

  localparam int N_DIR = 26;
  row_t dir_rows [N_DIR] = '{
    // pass-through, '+' to space, %fF in mixed case, '~' closing the message
    known_row(8'h41, 1'b0, 1'b1, 8'h41, ST_OK, 16'd1),
    known_row(CH_PLUS, 1'b0, 1'b1, CH_SPACE, ST_OK, 16'd2),
    plain_row(CH_PERCENT, 1'b0),
    plain_row(8'h66, 1'b0),
    plain_row(8'h46, 1'b0),
    known_row(CH_TILDE, 1'b1, 1'b1, CH_TILDE, ST_OK, 16'd4),
    // escape with a high-bit first digit: invalid pair, stays stopped to the end
    plain_row(CH_PERCENT, 1'b0),
    plain_row(8'h80, 1'b0),
    known_row(8'h31, 1'b0, 1'b0, 8'h00, ST_INVALID, 16'd0),
    known_row(8'h7A, 1'b1, 1'b0, 8'h00, ST_INVALID, 16'd0),
    // lone '%' as the whole message: nothing out
    known_row(CH_PERCENT, 1'b1, 1'b0, 8'h00, ST_OK, 16'd0),
    // '%' just before the last byte: last byte decoded as a plain character
    plain_row(CH_PERCENT, 1'b0),
    known_row(8'h5A, 1'b1, 1'b1, 8'h5A, ST_OK, 16'd1),
    // byte extremes as plain characters are invalid
    known_row(8'h00, 1'b1, 1'b0, 8'h00, ST_INVALID, 16'd0),
    known_row(8'hFF, 1'b0, 1'b0, 8'h00, ST_INVALID, 16'd0),
    known_row(CH_DASH, 1'b1, 1'b0, 8'h00, ST_INVALID, 16'd0),
    // zero capacity stops on the first byte
    cap_row(16'd0),
    known_row(8'h61, 1'b1, 1'b0, 8'h00, ST_FULL, 16'd0),
    // capacity 2: the second write fills it
    cap_row(16'd2),
    known_row(CH_UNDER, 1'b0, 1'b1, CH_UNDER, ST_OK, 16'd1),
    known_row(CH_DOT, 1'b0, 1'b1, CH_DOT, ST_FULL, 16'd2),
    known_row(8'h39, 1'b1, 1'b0, 8'h00, ST_FULL, 16'd2),
    // capacity lowered mid-message, seen at the next character
    known_row(8'h30, 1'b0, 1'b1, 8'h30, ST_OK, 16'd1),
    cap_row(16'd1),
    known_row(8'h71, 1'b1, 1'b0, 8'h00, ST_FULL, 16'd1),
    cap_row(CAP_RESET)
  };

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // tvalid stays up after a beat so back-to-back beats need no extra edge
  task automatic send_beat(input logic [7:0] c, input logic fin, input logic typed,
                           input result_t e);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    row_typed     <= typed;
    row_exp       <= e;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold the sender until every outstanding result beat has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_decodes.size() != 0);
  endtask

  // APB write of the capacity reg, then a read-back
  task automatic write_cap(input logic [15:0] v);
    logic [31:0] rd;
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_q    = v;
    penable <= 1'b0;        // psel held: this is the read's setup cycle
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd       = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd != {16'h0000, v})
      note_mismatch($sformatf("capacity read-back: want %h got %h", v, rd));
  endtask

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // One random message: mostly well-formed text and escapes, some broken escapes,
  // lone '%' (lands on the final or next-to-final byte now and then) and raw noise.
  task automatic send_message();
    logic [7:0] msg [$];
    int len, k, u;
    logic [7:0] c;
    len = $urandom_range(1, 14);
    while (msg.size() < len) begin
      k = $urandom_range(99);
      if (k < 45) begin
        u = $urandom_range(65);
        if (u < 26)      c = 8'(8'h41 + u);
        else if (u < 52) c = 8'(8'h61 + u - 26);
        else if (u < 62) c = 8'(8'h30 + u - 52);
        else case (u)
          62:      c = CH_DASH;
          63:      c = CH_UNDER;
          64:      c = CH_DOT;
          default: c = CH_TILDE;
        endcase
        msg.push_back(c);
      end else if (k < 55) begin
        msg.push_back(CH_PLUS);
      end else if (k < 78) begin
        msg.push_back(CH_PERCENT);
        msg.push_back(rand_hex());
        msg.push_back(rand_hex());
      end else if (k < 84) begin
        msg.push_back(CH_PERCENT);
        if ($urandom_range(1)) begin
          msg.push_back(8'($urandom_range(255)));
          msg.push_back(rand_hex());
        end else begin
          msg.push_back(rand_hex());
          msg.push_back(8'($urandom_range(255)));
        end
      end else if (k < 90) begin
        msg.push_back(CH_PERCENT);
      end else begin
        msg.push_back(8'($urandom_range(255)));
      end
    end
    for (int i = 0; i < msg.size(); i++)
      send_beat(msg[i], i == msg.size() - 1, 1'b0, '0);
    beats_sent += msg.size();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, none while calm
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the result beat first, then predict the accepted input beat,
  // so a stray result can never be matched against an item of the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t got, want, pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser[2:1],
               m_axis_tdata[23:8]};
        if (expected_decodes.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing expected: v=%0b b=%h l=%0b st=%0d n=%0d",
                                  got.data_valid, got.data_byte, got.end_of_message,
                                  got.status, got.byte_count));
        end else begin
          want = expected_decodes.pop_front();
          if (got !== want)
            note_mismatch($sformatf(
              "result mismatch: want v=%0b b=%h l=%0b st=%0d n=%0d, got v=%0b b=%h l=%0b st=%0d n=%0d",
              want.data_valid, want.data_byte, want.end_of_message, want.status, want.byte_count,
              got.data_valid, got.data_byte, got.end_of_message, got.status, got.byte_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = decode_byte(s_axis_tdata, s_axis_tlast);   // always step the model
        expected_decodes.push_back(row_typed ? row_exp : pred);
      end
    end
  end

  // Watchdog: too long with no beat moving on either side ends the run
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase, msgs;
    logic [15:0] cap_v;
    phase = 0;
    msgs  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_cap(dir_rows[i].cap);
      else send_beat(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].exp);
    end

    // random messages under a rotating set of capacities; phase 2 runs without idling
    while (beats_sent < RAND_BEATS) begin
      if (msgs % PHASE_MSGS == 0) begin
        case (phase % 6)
          0:       cap_v = CAP_RESET;
          1:       cap_v = 16'($urandom_range(1, 4));
          2:       cap_v = 16'($urandom_range(5, 20));
          3:       cap_v = 16'd0;
          4:       cap_v = 16'd1;
          default: cap_v = 16'($urandom_range(65535));
        endcase
        write_cap(cap_v);
        calm = (phase == 2);
        phase++;
      end
      send_message();
      msgs++;
      if ($urandom_range(9) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_decodes.size() != 0)
      note_mismatch($sformatf("%0d result beats never arrived", expected_decodes.size()));
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
